[sv/uru_pkg.sv]
// uru_pkg: command and status types shared by the remainder unit's controller
// and datapath; no dependencies
package uru_pkg;

	// controller to datapath commands
	typedef struct packed {
		logic load;   // capture a new request's operands
		logic step;   // one restoring subtract step
		logic store;  // write the finished remainder to the output register
	} uru_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic fast;   // divisor is zero or a power of two
	} uru_status_t;

endpackage

[sv/uru_datapath.sv]
// uru_datapath: operand registers, one-bit restoring subtract and output register
// depends on uru_pkg for the command and status types
module uru_datapath #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                    clk,
	input  logic [DATA_WIDTH-1:0]   dividend,
	input  logic [DATA_WIDTH-1:0]   divisor,
	input  uru_pkg::uru_cmd_t       cmd,
	output uru_pkg::uru_status_t    status,
	output logic [DATA_WIDTH-1:0]   remainder
);

	logic [DATA_WIDTH-1:0] dvd_q;
	logic [DATA_WIDTH-1:0] dsr_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] res_q;
	logic [DATA_WIDTH-1:0] dsr_m1;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   diff;
	logic [DATA_WIDTH-1:0] rem_next;
	logic [DATA_WIDTH-1:0] result;

	// zero and powers of two share the mask path: zero minus one is all ones
	assign dsr_m1      = dsr_q - {{(DATA_WIDTH-1){1'b0}}, 1'b1};
	assign status.fast = ((dsr_q & dsr_m1) == '0);

	// shift in the next dividend bit, subtract if it fits
	assign trial    = {rem_q, dvd_q[DATA_WIDTH-1]};
	assign diff     = trial - {1'b0, dsr_q};
	assign rem_next = diff[DATA_WIDTH] ? trial[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];

	assign result   = status.fast ? (dvd_q & dsr_m1) : rem_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (cmd.step) begin
			dvd_q <= {dvd_q[DATA_WIDTH-2:0], 1'b0};
			rem_q <= rem_next;
		end
		if (cmd.store) begin
			res_q <= result;
		end
	end

	assign remainder = res_q;

endmodule

[sv/uru_ctrl.sv]
// uru_ctrl: sequencer for the remainder unit, bit counter and output valid flag
// depends on uru_pkg for the command and status types
module uru_ctrl #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  uru_pkg::uru_status_t  status,
	output uru_pkg::uru_cmd_t     cmd
);

	localparam int CNT_W = $clog2(DATA_WIDTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BUSY,
		ST_FIN
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic               slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load  = in_valid && in_ready;
		cmd.step  = (state_q == ST_BUSY) && !status.fast;
		cmd.store = (state_q == ST_FIN) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result wins over the one just taken
			if (state_q == ST_FIN && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cnt_q   <= CNT_W'(DATA_WIDTH - 1);
						state_q <= ST_BUSY;
					end
				end
				ST_BUSY: begin
					if (status.fast || cnt_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[sv/unsigned_remainder_unit.sv]
// unsigned_remainder_unit: top level of the unsigned remainder unit
// depends on uru_pkg, uru_ctrl and uru_datapath
//
// Returns dividend modulo divisor for unsigned DATA_WIDTH-bit operands, one
// request at a time. A divisor of zero returns the dividend unchanged. When the
// divisor is zero or a power of two the result is a mask of the dividend and is
// written to the output register from the FIN state, with no subtract steps. Any
// other divisor goes through a restoring division that settles one quotient bit
// per cycle in the BUSY state and then writes the result from the FIN state; that
// bit-serial subtract loop sets the rate. The output register holds a finished
// result until it is taken, and the next request is accepted the cycle after the
// result is written, even if the previous result is still waiting. A result is
// only held up when the output register is still occupied at the moment a new
// one is ready.
module unsigned_remainder_unit #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	// result channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] remainder
);

	uru_pkg::uru_cmd_t    cmd;
	uru_pkg::uru_status_t status;

	// sequencer: accepts requests, counts division steps, owns output valid
	uru_ctrl #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// operands, partial remainder and the output register
	uru_datapath #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk       (clk),
		.dividend  (dividend),
		.divisor   (divisor),
		.cmd       (cmd),
		.status    (status),
		.remainder (remainder)
	);

endmodule

[sv/uru_checker.sv]
// uru_checker: port-level checks for unsigned_remainder_unit, bound to the top
// depends only on the top level's ports
module uru_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic [DATA_WIDTH-1:0] dividend,
	input logic [DATA_WIDTH-1:0] divisor,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [DATA_WIDTH-1:0] remainder
);

	// a waiting result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(remainder))
		else $error("result changed while stalled");

	// one request in flight at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// zero divisor passes the dividend through on the fast path
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid && divisor == '0
		|-> ##3 out_valid && remainder == $past(dividend, 3))
		else $error("zero divisor result wrong or late");

	// divisor of one gives zero on the fast path
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid && divisor == 1
		|-> ##3 out_valid && remainder == '0)
		else $error("unit divisor result wrong or late");

endmodule

bind unsigned_remainder_unit uru_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_uru_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.dividend  (dividend),
	.divisor   (divisor),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.remainder (remainder)
);
